FILE: rtl/nzmd_pkg.sv
// Package for the nearest zone match block: widths, reset values, codes and the
// structs passed between the front end, the back end and the top level.
// No dependencies.
package nzmd_pkg;

  localparam int unsigned MAX_ZONES_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 31;

  localparam int unsigned POS_W      = 31;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned ZCNT_W     = 7;
  localparam int unsigned DIST_W     = 63;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 63;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic [ZCNT_W-1:0] ZONE_COUNT_RST = '0;
  localparam logic [DIST_W-1:0] RADIUS_SQ_RST  = DIST_W'(4000000);
  localparam logic [CNT_W-1:0]  STABLE_RST     = CNT_W'(10);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_LOAD   = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_COUNT = 3'd0,
    CFG_RADIUS_SQ  = 3'd1,
    CFG_STABLE     = 3'd2,
    CFG_EMIT_EN    = 3'd3,
    CFG_EMIT_ONCE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_DONE
  } back_state_e;

  // Classified item as it sits in the queue; coordinates already sign-extended
  typedef struct packed {
    kind_e             kind;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
  } cmd_t;

  typedef struct packed {
    logic [ZCNT_W-1:0] zone_count;
    logic [DIST_W-1:0] radius_sq;
    logic [CNT_W-1:0]  stable_needed;
    logic              emit_en;
    logic              emit_once;
  } cfg_t;

endpackage

FILE: rtl/nzmd_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nzmd_pkg for the field widths.
interface nzmd_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [nzmd_pkg::SLOT_W-1:0]        slot;
  logic signed [nzmd_pkg::POS_W-1:0] pos_x;
  logic signed [nzmd_pkg::POS_W-1:0] pos_y;

  modport source (output valid, kind, slot, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, slot, pos_x, pos_y, output ready);
endinterface

interface nzmd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ready_res;
  logic                         found;
  logic [nzmd_pkg::SLOT_W-1:0]  zone_index;
  logic [nzmd_pkg::DIST_W-1:0]  dist_squared;
  logic                         emit_pose;

  modport source (output valid, ready_res, found, zone_index, dist_squared, emit_pose,
                  input ready);
  modport sink   (input valid, ready_res, found, zone_index, dist_squared, emit_pose,
                  output ready);
endinterface

FILE: rtl/nzmd_front.sv
// Front end: takes input items, classifies them into commands and holds them
// in a two-entry queue for the back end. Depends on nzmd_pkg and nzmd_in_if.
module nzmd_front #(
  parameter int unsigned MAX_ZONES  = nzmd_pkg::MAX_ZONES_DEF,
  parameter int unsigned COORD_BITS = nzmd_pkg::COORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  nzmd_in_if.sink        in_i,
  output logic           q_valid_o,
  input  logic           q_pop_i,
  output nzmd_pkg::cmd_t q_cmd_o
);

  nzmd_pkg::cmd_t cmd;
  nzmd_pkg::cmd_t q_mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  // Sign-extend from COORD_BITS and flag slots beyond the table
  always_comb begin
    cmd.kind    = nzmd_pkg::kind_e'(in_i.kind);
    cmd.slot    = in_i.slot;
    cmd.slot_ok = (32'(in_i.slot) < 32'(MAX_ZONES));
    cmd.pos_x   = nzmd_pkg::POS_W'($signed(in_i.pos_x[COORD_BITS-1:0]));
    cmd.pos_y   = nzmd_pkg::POS_W'($signed(in_i.pos_y[COORD_BITS-1:0]));
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = q_mem_q[rd_ptr_q];
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

FILE: rtl/nzmd_back.sv
// Back end: loads zone centers into the center memory, scans it per sample
// through a read/subtract/square/compare pipeline, debounces the nearest match
// and holds the result register. Depends on nzmd_pkg and nzmd_out_if.
module nzmd_back #(
  parameter int unsigned MAX_ZONES  = nzmd_pkg::MAX_ZONES_DEF,
  parameter int unsigned COORD_BITS = nzmd_pkg::COORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  nzmd_pkg::cmd_t q_cmd_i,
  input  nzmd_pkg::cfg_t cfg_i,
  nzmd_out_if.source     res_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned AW   = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int unsigned IW   = $clog2(MAX_ZONES + 1);
  localparam int unsigned NW   = (IW > nzmd_pkg::ZCNT_W) ? IW : nzmd_pkg::ZCNT_W;
  localparam int unsigned SQ_W = 2 * CB;
  localparam logic [IW-1:0] NONE = IW'(MAX_ZONES);

  // Center memory, undefined until loaded
  logic [CB-1:0] mem_x [MAX_ZONES];
  logic [CB-1:0] mem_y [MAX_ZONES];

  nzmd_pkg::back_state_e state_q, state_d;

  logic [IW-1:0] n_zones;
  logic [IW-1:0] issue_q, issue_nxt;
  logic          issue_last;
  logic          empty_q;
  logic [CB-1:0] cur_x_q, cur_y_q;

  logic                rd_v_q, sub_v_q, sq_v_q;
  logic [IW-1:0]       rd_idx_q, sub_idx_q, sq_idx_q;
  logic [CB-1:0]       rd_x_q, rd_y_q;
  logic [CB:0]         dx, dy, neg_x, neg_y;
  logic [CB-1:0]       mag_x_q, mag_y_q, mag_x_d, mag_y_d;
  logic [SQ_W-1:0]     sq_x_q, sq_y_q, sq_x_d, sq_y_d;
  logic [nzmd_pkg::DIST_W-1:0] dist_now;
  logic [nzmd_pkg::DIST_W-1:0] best_d_q;
  logic [IW-1:0]       best_idx_q;

  logic [IW-1:0]              tracked_q, tracked_d;
  logic [nzmd_pkg::CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic                       pose_sent_q, pose_sent_d;
  logic                       hit, ready_d, emit_d;

  logic                        res_valid_q, res_valid_d;
  logic                        res_ready_q, res_found_q, res_emit_q;
  logic [nzmd_pkg::SLOT_W-1:0] res_zone_q;
  logic [nzmd_pkg::DIST_W-1:0] res_dist_q;

  logic out_free, mem_we, start, issue_en, res_load;

  assign n_zones = (NW'(cfg_i.zone_count) > NW'(MAX_ZONES)) ? NONE
                                                            : IW'(cfg_i.zone_count);
  assign issue_nxt  = issue_q + IW'(1);
  assign issue_last = (issue_nxt == n_zones);
  assign out_free   = !res_valid_q || res_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nzmd_pkg::B_IDLE: begin
        if (q_valid_i && q_cmd_i.kind == nzmd_pkg::KIND_SAMPLE) begin
          state_d = (n_zones == '0) ? nzmd_pkg::B_DONE : nzmd_pkg::B_SCAN;
        end
      end
      nzmd_pkg::B_SCAN: begin
        if (issue_last) begin
          state_d = nzmd_pkg::B_DRAIN;
        end
      end
      nzmd_pkg::B_DRAIN: begin
        if (!rd_v_q && !sub_v_q && !sq_v_q) begin
          state_d = nzmd_pkg::B_DONE;
        end
      end
      nzmd_pkg::B_DONE: begin
        if (out_free) begin
          state_d = nzmd_pkg::B_IDLE;
        end
      end
      default: state_d = nzmd_pkg::B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o  = 1'b0;
    issue_en = 1'b0;
    res_load = 1'b0;
    case (state_q)
      nzmd_pkg::B_IDLE:  q_pop_o  = q_valid_i;
      nzmd_pkg::B_SCAN:  issue_en = 1'b1;
      nzmd_pkg::B_DRAIN: issue_en = 1'b0;
      nzmd_pkg::B_DONE:  res_load = out_free;
      default:           q_pop_o  = 1'b0;
    endcase
  end

  assign mem_we = q_pop_o && q_cmd_i.kind == nzmd_pkg::KIND_LOAD && q_cmd_i.slot_ok;
  assign start  = q_pop_o && q_cmd_i.kind == nzmd_pkg::KIND_SAMPLE;

  // Distance pipeline: absolute differences, then squares, then sum
  always_comb begin
    dx      = {cur_x_q[CB-1], cur_x_q} - {rd_x_q[CB-1], rd_x_q};
    dy      = {cur_y_q[CB-1], cur_y_q} - {rd_y_q[CB-1], rd_y_q};
    neg_x   = ~dx + (CB+1)'(1);
    neg_y   = ~dy + (CB+1)'(1);
    mag_x_d = dx[CB] ? neg_x[CB-1:0] : dx[CB-1:0];
    mag_y_d = dy[CB] ? neg_y[CB-1:0] : dy[CB-1:0];
    sq_x_d  = SQ_W'(mag_x_q) * SQ_W'(mag_x_q);
    sq_y_d  = SQ_W'(mag_y_q) * SQ_W'(mag_y_q);
    dist_now = nzmd_pkg::DIST_W'(sq_x_q) + nzmd_pkg::DIST_W'(sq_y_q);
  end

  // Debounce: same zone counts up, a new zone restarts at one, a miss clears
  always_comb begin
    hit = (best_d_q <= cfg_i.radius_sq);
    if (hit) begin
      if (tracked_q == best_idx_q) begin
        tracked_d = tracked_q;
        hit_cnt_d = (hit_cnt_q != nzmd_pkg::CNT_MAX) ? hit_cnt_q + 1'b1 : hit_cnt_q;
      end else begin
        tracked_d = best_idx_q;
        hit_cnt_d = nzmd_pkg::CNT_W'(1);
      end
    end else begin
      tracked_d = NONE;
      hit_cnt_d = '0;
    end
    ready_d     = (hit_cnt_d >= cfg_i.stable_needed);
    emit_d      = ready_d && cfg_i.emit_en && (!cfg_i.emit_once || !pose_sent_q);
    pose_sent_d = pose_sent_q || emit_d;
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nzmd_pkg::B_IDLE;
      issue_q     <= '0;
      empty_q     <= 1'b0;
      rd_v_q      <= 1'b0;
      sub_v_q     <= 1'b0;
      sq_v_q      <= 1'b0;
      tracked_q   <= NONE;
      hit_cnt_q   <= '0;
      pose_sent_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_v_q      <= issue_en;
      sub_v_q     <= rd_v_q;
      sq_v_q      <= sub_v_q;
      res_valid_q <= res_valid_d;
      if (start) begin
        issue_q <= '0;
        empty_q <= (n_zones == '0);
      end else if (issue_en) begin
        issue_q <= issue_nxt;
      end
      // Hold the debounce state on an empty search
      if (res_load && !empty_q) begin
        tracked_q   <= tracked_d;
        hit_cnt_q   <= hit_cnt_d;
        pose_sent_q <= pose_sent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[AW'(q_cmd_i.slot)] <= q_cmd_i.pos_x[CB-1:0];
      mem_y[AW'(q_cmd_i.slot)] <= q_cmd_i.pos_y[CB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      rd_x_q   <= mem_x[issue_q[AW-1:0]];
      rd_y_q   <= mem_y[issue_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_x_q <= q_cmd_i.pos_x[CB-1:0];
      cur_y_q <= q_cmd_i.pos_y[CB-1:0];
    end
    rd_idx_q  <= issue_q;
    sub_idx_q <= rd_idx_q;
    sq_idx_q  <= sub_idx_q;
    mag_x_q   <= mag_x_d;
    mag_y_q   <= mag_y_d;
    sq_x_q    <= sq_x_d;
    sq_y_q    <= sq_y_d;
    // First zone always taken; later ones must be strictly closer
    if (sq_v_q && (sq_idx_q == '0 || dist_now < best_d_q)) begin
      best_d_q   <= dist_now;
      best_idx_q <= sq_idx_q;
    end
    if (res_load) begin
      if (empty_q) begin
        res_ready_q <= 1'b0;
        res_found_q <= 1'b0;
        res_zone_q  <= '0;
        res_dist_q  <= nzmd_pkg::DIST_MAX;
        res_emit_q  <= 1'b0;
      end else begin
        res_ready_q <= ready_d;
        res_found_q <= 1'b1;
        res_zone_q  <= nzmd_pkg::SLOT_W'(best_idx_q);
        res_dist_q  <= best_d_q;
        res_emit_q  <= emit_d;
      end
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.ready_res    = res_ready_q;
  assign res_o.found        = res_found_q;
  assign res_o.zone_index   = res_zone_q;
  assign res_o.dist_squared = res_dist_q;
  assign res_o.emit_pose    = res_emit_q;

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nzmd_pkg::B_SCAN |-> issue_q < n_zones)
    else $error("scan address beyond the searched zones");

  a_pipe_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q || sub_v_q || sq_v_q) |->
      (state_q == nzmd_pkg::B_SCAN || state_q == nzmd_pkg::B_DRAIN))
    else $error("distance pipeline busy outside a scan");

  a_track_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tracked_q == NONE) == (hit_cnt_q == '0))
    else $error("tracked zone and hit count disagree");

  a_emit_marks_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_emit_q |-> pose_sent_q)
    else $error("pose emitted without marking it sent");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_found_q |->
      res_dist_q == nzmd_pkg::DIST_MAX && !res_ready_q && !res_emit_q)
    else $error("empty search result malformed");

endmodule

FILE: rtl/nearest_zone_match_debounce_core.sv
// Nearest zone match with debounce. A load item (kind 1) writes one zone centre
// into the centre memory, unless its slot is MAX_ZONES or above, and gives no
// result; the memory is not cleared at reset, so every entry below zone_count
// must be loaded before samples are sent. A position sample (kind 0) gives one
// result: the first nearest of the first zone_count zones by squared distance,
// debounced into a ready flag and a pose emit flag. A load item is written as
// the back end takes it; a sample is scanned one centre per cycle from the
// single-port centre memory through the read, subtract, square and compare
// stages before the next item is taken. A two-entry queue sits between the input
// and the back end, and the result register lets the next item be taken while a
// result waits. The user must write configuration through cfg_we_i/cfg_idx_i/
// cfg_data_i only while the block is idle; the block itself does not enforce this.
module nearest_zone_match_debounce_core #(
  parameter int unsigned MAX_ZONES  = nzmd_pkg::MAX_ZONES_DEF,
  parameter int unsigned COORD_BITS = nzmd_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  nzmd_in_if.sink                           in_i,
  nzmd_out_if.source                        res_o,
  input  logic                              cfg_we_i,
  input  logic [nzmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nzmd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  nzmd_pkg::cfg_t cfg_q, cfg_d;
  nzmd_pkg::cmd_t q_cmd;
  logic           q_valid, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nzmd_pkg::CFG_ZONE_COUNT: cfg_d.zone_count    = cfg_data_i[nzmd_pkg::ZCNT_W-1:0];
        nzmd_pkg::CFG_RADIUS_SQ:  cfg_d.radius_sq     = cfg_data_i[nzmd_pkg::DIST_W-1:0];
        nzmd_pkg::CFG_STABLE:     cfg_d.stable_needed = cfg_data_i[nzmd_pkg::CNT_W-1:0];
        nzmd_pkg::CFG_EMIT_EN:    cfg_d.emit_en       = cfg_data_i[0];
        nzmd_pkg::CFG_EMIT_ONCE:  cfg_d.emit_once     = cfg_data_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zone_count    <= nzmd_pkg::ZONE_COUNT_RST;
      cfg_q.radius_sq     <= nzmd_pkg::RADIUS_SQ_RST;
      cfg_q.stable_needed <= nzmd_pkg::STABLE_RST;
      cfg_q.emit_en       <= 1'b1;
      cfg_q.emit_once     <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nzmd_front #(
    .MAX_ZONES  (MAX_ZONES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_cmd_o   (q_cmd)
  );

  nzmd_back #(
    .MAX_ZONES  (MAX_ZONES),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_cmd_i   (q_cmd),
    .cfg_i     (cfg_q),
    .res_o     (res_o)
  );

endmodule
